@@ rtl/core/adagrad_parameter_update_assert.svh @@
// Assertion macros used by the top-level RTL module
`ifndef ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH
`define ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH

// Same-cycle implication
`define APU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("apu assertion failed");

// Next-cycle implication
`define APU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("apu assertion failed");

`endif

@@ rtl/core/apu_pkg.sv @@
`timescale 1ns / 1ps
package apu_pkg;

    localparam int PARAM_COUNT_DEF = 4096;

    localparam int IDX_W   = 12;
    localparam int GRAD_W  = 32;
    localparam int BATCH_W = 16;
    localparam int LR_W    = 24;
    localparam int ACC_W   = 64;
    localparam int ROOT_W  = ACC_W / 2;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int BSQ_W   = 2 * BATCH_W;
    localparam int NUM_W   = LR_W + GRAD_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DEN_W-1:0] EPSILON_Q16 = DEN_W'(7);
    localparam logic [LR_W-1:0]  LR_RESET    = LR_W'(655);

    localparam logic REG_LEARNING_RATE = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [GRAD_W-1:0] mag;
        logic              neg;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  sat;
    } side_sat_t;

endpackage

@@ rtl/core/apu_ram.sv @@
`timescale 1ns / 1ps
module apu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/apu_div.sv @@
`timescale 1ns / 1ps
module apu_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vld_prev;
        logic [NW-1:0] nq_prev;
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   shifted;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign nq_prev   = in_num;
            assign rem_prev  = '0;
            assign den_prev  = in_den;
            assign side_prev = in_side;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign nq_prev   = nq_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            shifted  = {rem_prev, nq_prev[NW-1]};
            ge       = shifted >= {1'b0, den_prev};
            diff     = shifted - {1'b0, den_prev};
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            nq_next  = {nq_prev[NW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]   <= nq_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign out_quo  = nq_reg[NW-1];
    assign out_side = side_reg[NW-1];

endmodule

@@ rtl/core/apu_sqrt.sv @@
`timescale 1ns / 1ps
module apu_sqrt #(
    parameter int SW = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [apu_pkg::ACC_W-1:0] in_rad,
    input  logic [SW-1:0]             in_side,
    output logic                      out_vld,
    output logic [apu_pkg::ROOT_W-1:0] out_root,
    output logic [SW-1:0]             out_side
);

    localparam int RW = apu_pkg::ROOT_W;
    localparam int AW = apu_pkg::ACC_W;

    logic          vld_reg  [RW];
    logic [AW-1:0] rad_reg  [RW];
    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          vld_prev;
        logic [AW-1:0] rad_prev;
        logic [RW+1:0] rem_prev;
        logic [RW-1:0] root_prev;
        logic [SW-1:0] side_prev;
        logic [RW+3:0] shifted;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            shifted = {rem_prev, rad_prev[AW-1:AW-2]};
            trial   = {2'b00, root_prev, 2'b01};
            ge      = shifted >= trial;
            diff    = shifted - trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_prev[AW-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
                root_reg[k] <= {root_prev[RW-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

@@ rtl/core/adagrad_parameter_update.sv @@
// Adagrad parameter update, fully pipelined.
// Throughput one word per cycle while m_ready does not stall the output register;
// the per-bit divider and square-root stages are fully pipelined.
// Reset: synchronous, active low; learning_rate returns to 655 and the accumulator
// store is swept to zero, entry by entry, while s_ready stays low.
`timescale 1ns / 1ps
module adagrad_parameter_update #(
    parameter int PARAM_COUNT = apu_pkg::PARAM_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apu_pkg::PADDR_W-1:0]  paddr,
    input  logic [apu_pkg::PDATA_W-1:0]  pwdata,
    output logic [apu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [apu_pkg::IDX_W-1:0]    s_param_index,
    input  logic signed [apu_pkg::GRAD_W-1:0] s_gradient_sum,
    input  logic [apu_pkg::BATCH_W-1:0]  s_batch_size,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [apu_pkg::IDX_W-1:0]    m_param_index_out,
    output logic signed [apu_pkg::GRAD_W-1:0] m_scaled_delta,
    output logic                         m_saturated
);

    `include "adagrad_parameter_update_assert.svh"

    localparam int AW  = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int SW1 = $bits(apu_pkg::side_t);
    localparam int SW2 = $bits(apu_pkg::side_sat_t);

    logic advance;
    logic accept;

    logic [apu_pkg::LR_W-1:0] lr_reg;

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    logic                          s0_vld_reg;
    apu_pkg::side_t                s0_side_reg;
    logic [apu_pkg::BATCH_W-1:0]   s0_b_reg;

    logic                          s1_vld_reg;
    apu_pkg::side_t                s1_side_reg;
    logic [apu_pkg::ACC_W-1:0]     s1_sq_reg;
    logic [apu_pkg::BSQ_W-1:0]     s1_bb_reg;

    logic                          d1_vld;
    logic [apu_pkg::ACC_W-1:0]     d1_inc;
    logic [SW1-1:0]                d1_side_bits;
    apu_pkg::side_t                d1_side;

    logic                          s2_vld_reg;
    apu_pkg::side_t                s2_side_reg;
    logic [apu_pkg::ACC_W-1:0]     s2_inc_reg;
    logic [apu_pkg::ACC_W-1:0]     ram_rdata;
    logic                          s2_in_store;
    logic                          s2_hit;
    logic [apu_pkg::ACC_W-1:0]     s2_old;
    logic [apu_pkg::ACC_W:0]       s2_sum;
    logic [apu_pkg::ACC_W-1:0]     s2_acc;

    logic                          fwd_vld_reg;
    logic [apu_pkg::IDX_W-1:0]     fwd_idx_reg;
    logic [apu_pkg::ACC_W-1:0]     fwd_val_reg;

    logic                          ram_we;
    logic                          upd_we;
    logic [AW-1:0]                 ram_waddr;
    logic [apu_pkg::ACC_W-1:0]     ram_wdata;

    logic                          s3_vld_reg;
    apu_pkg::side_sat_t            s3_side_reg;
    logic [apu_pkg::ACC_W-1:0]     s3_acc_reg;

    logic                          sq_vld;
    logic [apu_pkg::ROOT_W-1:0]    sq_root;
    logic [SW2-1:0]                sq_side_bits;
    apu_pkg::side_sat_t            sq_side;

    logic                          s4_vld_reg;
    apu_pkg::side_sat_t            s4_side_reg;
    logic [apu_pkg::DEN_W-1:0]     s4_den_reg;
    logic [apu_pkg::NUM_W-1:0]     s4_num_reg;

    logic                          d2_vld;
    logic [apu_pkg::NUM_W-1:0]     d2_quo;
    logic [SW2-1:0]                d2_side_bits;
    apu_pkg::side_sat_t            d2_side;

    logic [apu_pkg::GRAD_W-1:0]    q_clamp;
    logic                          q_sat;
    logic [apu_pkg::GRAD_W-1:0]    delta;

    logic                          m_valid_reg;
    logic [apu_pkg::IDX_W-1:0]     m_idx_reg;
    logic [apu_pkg::GRAD_W-1:0]    m_delta_reg;
    logic                          m_sat_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance && !clearing_reg;
    assign accept  = s_valid && s_ready;

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == apu_pkg::REG_LEARNING_RATE) begin
            prdata = apu_pkg::PDATA_W'(lr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= apu_pkg::LR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == apu_pkg::REG_LEARNING_RATE) begin
            lr_reg <= pwdata[apu_pkg::LR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == AW'(PARAM_COUNT - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else if (advance) begin
            s0_vld_reg <= accept;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= d1_vld;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s0_side_reg.idx <= s_param_index;
            s0_side_reg.neg <= s_gradient_sum[apu_pkg::GRAD_W-1];
            s0_side_reg.mag <= s_gradient_sum[apu_pkg::GRAD_W-1]
                             ? apu_pkg::GRAD_W'(-s_gradient_sum)
                             : apu_pkg::GRAD_W'(s_gradient_sum);
            s0_b_reg        <= (s_batch_size == '0) ? apu_pkg::BATCH_W'(1) : s_batch_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_side_reg <= s0_side_reg;
            s1_sq_reg   <= apu_pkg::ACC_W'(s0_side_reg.mag) * apu_pkg::ACC_W'(s0_side_reg.mag);
            s1_bb_reg   <= apu_pkg::BSQ_W'(s0_b_reg) * apu_pkg::BSQ_W'(s0_b_reg);
        end
    end

    apu_div #(
        .NW (apu_pkg::ACC_W),
        .DW (apu_pkg::BSQ_W),
        .SW (SW1)
    ) u_inc_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (s1_vld_reg),
        .in_num   (s1_sq_reg),
        .in_den   (s1_bb_reg),
        .in_side  (SW1'(s1_side_reg)),
        .out_vld  (d1_vld),
        .out_quo  (d1_inc),
        .out_side (d1_side_bits)
    );

    assign d1_side = apu_pkg::side_t'(d1_side_bits);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_side_reg <= d1_side;
            s2_inc_reg  <= d1_inc;
        end
    end

    always_comb begin
        s2_in_store = 32'(s2_side_reg.idx) < 32'(PARAM_COUNT);
        s2_hit      = fwd_vld_reg && (fwd_idx_reg == s2_side_reg.idx);
        s2_old      = '0;
        if (s2_in_store) begin
            s2_old = s2_hit ? fwd_val_reg : ram_rdata;
        end
        s2_sum = {1'b0, s2_old} + {1'b0, s2_inc_reg};
        s2_acc = s2_sum[apu_pkg::ACC_W] ? '1 : s2_sum[apu_pkg::ACC_W-1:0];
    end

    assign upd_we    = advance && s2_vld_reg && s2_in_store;
    assign ram_we    = clearing_reg || upd_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : AW'(s2_side_reg.idx);
    assign ram_wdata = clearing_reg ? '0 : s2_acc;

    apu_ram #(
        .WIDTH (apu_pkg::ACC_W),
        .DEPTH (PARAM_COUNT)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (AW'(d1_side.idx)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= 1'b0;
        end else if (upd_we) begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_we) begin
            fwd_idx_reg <= s2_side_reg.idx;
            fwd_val_reg <= s2_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_side_reg.side <= s2_side_reg;
            s3_side_reg.sat  <= s2_sum[apu_pkg::ACC_W];
            s3_acc_reg       <= s2_acc;
        end
    end

    apu_sqrt #(
        .SW (SW2)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (s3_vld_reg),
        .in_rad   (s3_acc_reg),
        .in_side  (SW2'(s3_side_reg)),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side_bits)
    );

    assign sq_side = apu_pkg::side_sat_t'(sq_side_bits);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s4_side_reg <= sq_side;
            s4_den_reg  <= apu_pkg::DEN_W'(sq_root) + apu_pkg::EPSILON_Q16;
            s4_num_reg  <= apu_pkg::NUM_W'(lr_reg) * apu_pkg::NUM_W'(sq_side.side.mag);
        end
    end

    apu_div #(
        .NW (apu_pkg::NUM_W),
        .DW (apu_pkg::DEN_W),
        .SW (SW2)
    ) u_delta_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (s4_vld_reg),
        .in_num   (s4_num_reg),
        .in_den   (s4_den_reg),
        .in_side  (SW2'(s4_side_reg)),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_side (d2_side_bits)
    );

    assign d2_side = apu_pkg::side_sat_t'(d2_side_bits);

    always_comb begin
        if (d2_side.side.neg) begin
            q_sat   = d2_quo > apu_pkg::NUM_W'(32'h7FFF_FFFF);
            q_clamp = q_sat ? 32'h7FFF_FFFF : d2_quo[apu_pkg::GRAD_W-1:0];
            delta   = q_clamp;
        end else begin
            q_sat   = d2_quo > apu_pkg::NUM_W'(32'h8000_0000);
            q_clamp = q_sat ? 32'h8000_0000 : d2_quo[apu_pkg::GRAD_W-1:0];
            delta   = apu_pkg::GRAD_W'(0) - q_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_idx_reg   <= d2_side.side.idx;
            m_delta_reg <= delta;
            m_sat_reg   <= d2_side.sat || q_sat;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_param_index_out = m_idx_reg;
    assign m_scaled_delta    = $signed(m_delta_reg);
    assign m_saturated       = m_sat_reg;

    `APU_ASSERT_NXT(a_clear_no_entry, aclk, aresetn, clearing_reg, !s0_vld_reg)
    `APU_ASSERT_IMP(a_clear_pipe_empty, aclk, aresetn, clearing_reg, !s2_vld_reg && !fwd_vld_reg)
    `APU_ASSERT_IMP(a_acc_clip_max, aclk, aresetn, s3_vld_reg && s3_side_reg.sat, s3_acc_reg == '1)
    `APU_ASSERT_IMP(a_den_nonzero, aclk, aresetn, s4_vld_reg, s4_den_reg != '0)

endmodule
